// File: hw/rtl/sha_pkg.sv
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       wr_byte;    // write byte into block store, advance fill
        logic [7:0] wr_data;
        logic       cnt_byte;   // count one message byte
        logic       load;       // copy hash words into working words
        logic       round;      // run one compression round
        logic [5:0] rnd;        // round number
        logic       fold;       // add working words into hash words
        logic       reinit;     // restore initial values, clear counters
        logic [2:0] len_sel;    // length byte select
        logic       len_mode;   // write length byte instead of wr_data
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
    } t_stat;

    // input item commands
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: hw/rtl/sha_datapath.sv
module sha_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha_pkg::t_cmd  i_cmd,
    output sha_pkg::t_stat o_stat,
    input  logic [2:0]     i_word_sel,
    output logic [31:0]    o_word
);
    import sha_pkg::*;

    logic [31:0] r_blk [16];
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bytes, n_bytes;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];

    logic [63:0] bits;
    logic [7:0]  byte_in;
    logic [31:0] blk_word, w, w15, w2, t1, t2;

    assign bits    = {r_bytes[60:0], 3'b000};
    assign byte_in = i_cmd.len_mode ? bits[{~i_cmd.len_sel, 3'b000} +: 8] : i_cmd.wr_data;

    // block held as 16 big-endian words; each byte lands in its lane
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_blk[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= byte_in;
        end
    end

    assign blk_word = r_blk[i_cmd.rnd[3:0]];

    always_comb begin
        w15 = r_w[4'(i_cmd.rnd[3:0] - 4'd15)];
        w2  = r_w[4'(i_cmd.rnd[3:0] - 4'd2)];
        if (i_cmd.rnd < 6'd16) begin
            w = blk_word;
        end else begin
            w = r_w[i_cmd.rnd[3:0]]
                + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                + r_w[4'(i_cmd.rnd[3:0] - 4'd7)]
                + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
        end
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_TAB[i_cmd.rnd] + w;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_w[i_cmd.rnd[3:0]] <= w;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_bytes = r_bytes;
        if (i_cmd.wr_byte)  n_fill  = r_fill + 6'd1;
        if (i_cmd.cnt_byte) n_bytes = r_bytes + 64'd1;
        if (i_cmd.reinit) begin
            n_fill  = '0;
            n_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_bytes <= '0;
            r_h     <= H_INIT;
        end else begin
            r_fill  <= n_fill;
            r_bytes <= n_bytes;
            if (i_cmd.reinit) begin
                r_h <= H_INIT;
            end else if (i_cmd.fold) begin
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= r_h[j] + r_v[j];
                end
            end
        end
    end

    assign o_stat.fill = r_fill;
    assign o_word      = r_h[i_word_sel];
endmodule

// File: hw/rtl/sha_ctrl.sv
module sha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_command,
    input  logic [7:0]     i_data_byte,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_word_idx,
    output sha_pkg::t_cmd  o_cmd,
    input  sha_pkg::t_stat i_stat
);
    import sha_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_cnt, n_cnt;
    logic       r_fin, n_fin;   // compression belongs to a finish
    logic       r_len, n_len;   // writing length bytes

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_len   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
            r_len   <= n_len;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rnd      = r_rnd;
        n_cnt      = r_cnt;
        n_fin      = r_fin;
        n_len      = r_len;
        o_cmd      = '0;
        o_cmd.rnd  = r_rnd;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_word_idx = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_byte = 1'b1;
                    if (i_command == CMD_DATA) begin
                        o_cmd.wr_data  = i_data_byte;
                        o_cmd.cnt_byte = 1'b1;
                        n_fin = 1'b0;
                        if (i_stat.fill == 6'd63) n_state = ST_LOAD;
                    end else begin
                        o_cmd.wr_data = PAD_BYTE;
                        n_fin = 1'b1;
                        n_len = 1'b0;
                        n_cnt = '0;
                        n_state = (i_stat.fill == 6'd63) ? ST_LOAD : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.wr_byte = 1'b1;
                if (r_len) begin
                    o_cmd.len_mode = 1'b1;
                    o_cmd.len_sel  = r_cnt;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) n_state = ST_LOAD;
                end else begin
                    if (i_stat.fill == LENGTH_POS) begin
                        o_cmd.len_mode = 1'b1;
                        o_cmd.len_sel  = 3'd0;
                        n_len = 1'b1;
                        n_cnt = 3'd1;
                    end else if (i_stat.fill == 6'd63) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_rnd = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_len) begin
                    n_cnt = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        o_cmd.reinit = 1'b1;
                        n_fin = 1'b0;
                        n_len = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/sha256_stream_hasher.sv
// Channel | Signals                         | Item
// s_axis  | tvalid tready tdata[7:0] tuser  | tdata: data_byte; tuser: command
// m_axis  | tvalid tready tdata[39:0] tlast | tdata: digest_word, word_index
//
// Data bytes are accepted one per cycle while idle; the 64th byte of a block starts
// a compression (load, 64 rounds of one shared round unit, fold).
// A finish runs padding one byte per cycle, one or two compressions, then
// presents eight digest words, one per accepted output cycle.
// Reset (synchronous, active low) restores the initial hash and clears counts.
// Input is refused during compression and digest output; output stalls hold.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [2:0] word_idx;
    logic [31:0] word;

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid), .o_in_ready (s_axis_tready),
        .i_command (s_axis_tuser), .i_data_byte (s_axis_tdata),
        .o_out_valid (m_axis_tvalid), .i_out_ready (m_axis_tready),
        .o_word_idx (word_idx), .o_cmd (cmd), .i_stat (stat)
    );

    sha_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd (cmd), .o_stat (stat),
        .i_word_sel (word_idx), .o_word (word)
    );

    assign m_axis_tdata = {5'd0, word_idx, word};
    assign m_axis_tlast = (word_idx == 3'd7);
endmodule

// File: hw/rtl/sha_checker.sv
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast mismatch");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[34:32] == 3'($past(m_axis_tdata[34:32]) + 3'd1)))
        else $error("word index skipped");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);

// File: bench/sha_digest_checker.sv
`timescale 1ns / 1ps

module sha_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          o_errors,
    output int          o_pending
);
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [63:0]  msg_len;
    t_digest_word digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int j = 0; j < 8; j++) v[j] = chain[j];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
    endtask

    task automatic absorb(input logic [7:0] b);
        blk[fill] = b;
        fill = fill + 6'd1;
        if (fill == 6'd0) compress_block();
    endtask

    task automatic predict_item(input logic cmd, input logic [7:0] b);
        logic [63:0] bits;
        t_digest_word dw;
        if (cmd == CMD_DATA) begin
            absorb(b);
            msg_len = msg_len + 64'd1;
        end else begin
            bits = msg_len << 3;
            absorb(PAD_BYTE);
            while (fill != LENGTH_POS) absorb(8'h00);
            for (int i = 0; i < 8; i++) absorb(bits[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                dw.word = chain[i];
                dw.idx  = 3'(i);
                dw.last = (i == 7);
                digest_q = {digest_q, dw};
            end
            for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
            fill    = '0;
            msg_len = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_word want;
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
            fill     = '0;
            msg_len  = '0;
            digest_q.delete();
            o_errors <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = digest_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.word || m_axis_tdata[34:32] !== want.idx
                        || m_axis_tlast !== want.last || m_axis_tdata[39:35] !== 5'd0) begin
                        $display("%0t: digest mismatch expected word %h idx %0d last %b,",
                                 $time, want.word, want.idx, want.last,
                                 " got word %h idx %0d last %b",
                                 m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = digest_q.size();
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import sha_pkg::*;

    localparam int   IDLE_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;
    int          errors;
    int          pending;
    int          quiet_cycles = 0;

    sha256_stream_hasher dut (.*);

    sha_digest_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: count cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stall before each item, with stretches of none
    initial begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    // send one item, holding it until accepted; gap drawn per item
    task automatic send_item(input logic cmd, input logic [7:0] b, input bit gaps);
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 13) : 0;
        if (wait_n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        @(posedge i_clk iff s_axis_tready);
    endtask

    // message of len random bytes followed by a finish
    task automatic send_message(input int len, input bit gaps);
        for (int k = 0; k < len; k++) send_item(CMD_DATA, 8'($urandom), gaps);
        send_item(CMD_FINISH, 8'($urandom), gaps);
    endtask

    initial begin
        int len;
        bit gaps;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_DATA;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, finish with data bits set, extreme bytes
        send_item(CMD_FINISH, 8'h00, 1'b0);
        send_item(CMD_FINISH, 8'hff, 1'b1);
        send_item(CMD_DATA, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hff, 1'b1);
        send_item(CMD_DATA, 8'h55, 1'b0);
        send_item(CMD_DATA, 8'haa, 1'b0);
        send_item(CMD_FINISH, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'h61, 1'b0);
        send_item(CMD_DATA, 8'h62, 1'b0);
        send_item(CMD_DATA, 8'h63, 1'b0);
        send_item(CMD_FINISH, 8'h80, 1'b1);

        // random: messages around block boundaries (55/56 padding split, 63/64)
        for (int total = 0; total < 360; ) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(62, 65);
                3: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 40);
            endcase
            if (len > 359 - total) len = 359 - total;
            gaps = ($urandom_range(0, 2) != 0);
            send_message(len, gaps);
            total += len + 1;
        end
        s_axis_tvalid <= 1'b0;

        // drain, then let any trailing work settle
        @(posedge i_clk iff pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
